// ===== sv/cwfl_pkg.sv =====
package cwfl_pkg;

  // Fixed field and datapath widths.
  localparam int unsigned LINE_W      = 24;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned WIN_W       = 16;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned WG_W        = 32;
  localparam int unsigned PROD_W      = 56;
  // A line value times a weighted window stays within +-2^53.
  localparam int unsigned PROD_MAG_W  = 54;
  localparam int unsigned FRAC_SHIFT  = 23;
  localparam int unsigned TAPS_CFG_W  = 7;
  localparam int unsigned STG_CFG_W   = 4;
  localparam int unsigned COEFF_IDX_W = 6;
  localparam int unsigned CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;

  // Request types.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEFF  = 1'b1;

  // Register reset values.
  localparam logic [TAPS_CFG_W-1:0]  TAPS_RST  = 7'd16;
  localparam logic [STG_CFG_W-1:0]   STG_RST   = 4'd1;
  localparam logic signed [GAIN_W-1:0] GAIN_RST = 16'sd256;

  // Output saturation limits.
  localparam logic signed [LINE_W-1:0] RES_MAX = 24'sh7FFFFF;
  localparam logic signed [LINE_W-1:0] RES_MIN = 24'sh800000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic coeff_wr;
    logic start;
    logic issue;
    logic div_start;
    logic next_stage;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic tap_last;
    logic pipe_busy;
    logic div_done;
    logic stage_last;
    logic out_full;
  } sts_t;

endpackage

// ===== sv/cwfl_dp.sv =====
module cwfl_dp import cwfl_pkg::*; #(
  parameter int unsigned MAX_TAPS   = 64,
  parameter int unsigned MAX_STAGES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  input  logic [COEFF_IDX_W-1:0]      coeff_index_i,
  input  logic signed [WIN_W-1:0]     coeff_value_i,
  input  logic                        cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [GAIN_W-1:0]           cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic signed [LINE_W-1:0]    filtered_o
);

  localparam int unsigned TAP_AW     = $clog2(MAX_TAPS);
  localparam int unsigned TAPS_W     = $clog2(MAX_TAPS + 1);
  localparam int unsigned STG_AW     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned LINE_DEPTH = MAX_STAGES * MAX_TAPS;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  localparam int unsigned WIN_SPAN   = 1 << COEFF_IDX_W;
  localparam int unsigned WIN_DEPTH  = (MAX_TAPS < WIN_SPAN) ? MAX_TAPS : WIN_SPAN;
  localparam int unsigned WIN_AW     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  // The sum of up to MAX_TAPS products needs one more bit per doubling of taps.
  localparam int unsigned ACC_W      = PROD_MAG_W + TAP_AW;
  localparam int unsigned DIVD_W     = ACC_W - FRAC_SHIFT;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVD_W + 1);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = DIV_CNT_W'(DIVD_W);
  localparam logic [DIVD_W-1:0]    MAG_POS_MAX = DIVD_W'(8388607);
  localparam logic [DIVD_W-1:0]    MAG_NEG_MAX = DIVD_W'(8388608);

  logic [TAPS_CFG_W-1:0]      taps_q;
  logic [STG_CFG_W-1:0]       stages_q;
  logic signed [GAIN_W-1:0]   gain_q;

  logic [TAPS_W-1:0]          taps_eff;
  logic [TAP_AW-1:0]          tap_last_idx;
  logic [STG_AW-1:0]          stg_last_idx;

  logic [TAP_AW-1:0]          tap_q;
  logic [STG_AW-1:0]          stage_q;
  logic [LINE_AW-1:0]         clr_addr_q;
  logic [LINE_AW-1:0]         rd_addr;
  logic [LINE_AW-1:0]         wa1_q;
  logic                       v1_q, v2_q, v3_q;

  logic signed [LINE_W-1:0]   line_mem [LINE_DEPTH];
  logic signed [LINE_W-1:0]   line_rd_q;
  logic                       wr_en;
  logic [LINE_AW-1:0]         wr_addr;
  logic signed [LINE_W-1:0]   wr_data;

  logic signed [WIN_W-1:0]    win_mem [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]       win_vld_q;
  logic signed [WIN_W-1:0]    win_rd_q;
  logic                       win_ok_q;
  logic [TAP_AW-1:0]          win_idx;
  logic [WIN_AW-1:0]          win_addr;
  logic                       win_in_range;
  logic                       coeff_hit;

  logic signed [LINE_W-1:0]   carry_q;
  logic signed [LINE_W-1:0]   line2_q;
  logic signed [WG_W-1:0]     wg2_q;
  logic signed [PROD_W-1:0]   prod3_q;
  logic signed [ACC_W-1:0]    acc_q;

  logic [ACC_W-1:0]           acc_mag;
  logic [DIV_CNT_W-1:0]       div_cnt_q;
  logic [DIVD_W-1:0]          quo_q;
  logic [TAPS_W-1:0]          rem_q;
  logic [TAPS_W:0]            rem_sh;
  logic                       q_bit;
  logic                       neg_q;
  logic signed [LINE_W-1:0]   res;

  logic                       out_valid_q;
  logic signed [LINE_W-1:0]   out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q   <= TAPS_RST;
      stages_q <= STG_RST;
      gain_q   <= GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TAPS:   taps_q   <= cfg_data_i[TAPS_CFG_W-1:0];
        CFG_STAGES: stages_q <= cfg_data_i[STG_CFG_W-1:0];
        CFG_GAIN:   gain_q   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Clamp tap and stage counts to the supported range.
  always_comb begin
    if (taps_q < 7'd2) begin
      taps_eff = TAPS_W'(2);
    end else if (int'(taps_q) > MAX_TAPS) begin
      taps_eff = TAPS_W'(MAX_TAPS);
    end else begin
      taps_eff = TAPS_W'(taps_q);
    end
    if (stages_q == '0) begin
      stg_last_idx = '0;
    end else if (int'(stages_q) > MAX_STAGES) begin
      stg_last_idx = STG_AW'(MAX_STAGES - 1);
    end else begin
      stg_last_idx = STG_AW'(stages_q - 4'd1);
    end
  end

  assign tap_last_idx = TAP_AW'(taps_eff - 1'b1);

  // Walk counters, pipeline valids, clearing sweep and divider count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q      <= '0;
      stage_q    <= '0;
      clr_addr_q <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      priority if (cmd_i.start) begin
        tap_q   <= '0;
        stage_q <= '0;
      end else if (cmd_i.next_stage) begin
        tap_q   <= '0;
        stage_q <= stage_q + 1'b1;
      end else if (cmd_i.issue) begin
        tap_q   <= tap_q + 1'b1;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= DIV_STEPS;
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
    end
  end

  // Delay-line memory: one read and one write port, registered read.
  assign rd_addr = LINE_AW'(int'(stage_q) * MAX_TAPS + int'(tap_q));
  assign wr_en   = cmd_i.clear | v1_q;
  assign wr_addr = cmd_i.clear ? clr_addr_q : wa1_q;
  assign wr_data = cmd_i.clear ? '0 : carry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    line_rd_q <= line_mem[rd_addr];
    wa1_q     <= rd_addr;
  end

  // Window table; tap i is weighted by entry T-1-i.
  assign win_idx      = tap_last_idx - tap_q;
  assign win_addr     = WIN_AW'(win_idx);
  assign win_in_range = int'(win_idx) < WIN_DEPTH;
  assign coeff_hit    = cmd_i.coeff_wr && (int'(coeff_index_i) < WIN_DEPTH);

  always_ff @(posedge clk_i) begin
    if (coeff_hit) begin
      win_mem[WIN_AW'(coeff_index_i)] <= coeff_value_i;
    end
    win_rd_q <= win_mem[win_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
      win_ok_q  <= 1'b0;
    end else begin
      if (coeff_hit) begin
        win_vld_q[WIN_AW'(coeff_index_i)] <= 1'b1;
      end
      win_ok_q <= win_in_range && win_vld_q[win_addr];
    end
  end

  // Multiply-accumulate pipeline and shift carry.
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.start) begin
      carry_q <= LINE_W'(sample_in_i);
    end else if (cmd_i.next_stage) begin
      carry_q <= res;
    end else if (v1_q) begin
      carry_q <= line_rd_q;
    end
    line2_q <= line_rd_q;
    wg2_q   <= win_ok_q ? win_rd_q * gain_q : WG_W'(0);
    prod3_q <= line2_q * wg2_q;
    if (cmd_i.start || cmd_i.next_stage) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + ACC_W'(prod3_q);
    end
  end

  // Restoring divider by the tap count, one quotient bit per cycle.
  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign rem_sh  = {rem_q, quo_q[DIVD_W-1]};
  assign q_bit   = rem_sh >= {1'b0, taps_eff};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= acc_q[ACC_W-1];
      quo_q <= acc_mag[FRAC_SHIFT +: DIVD_W];
      rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      rem_q <= q_bit ? TAPS_W'(rem_sh - {1'b0, taps_eff}) : rem_sh[TAPS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], q_bit};
    end
  end

  // Apply sign and saturate to 24 bits.
  always_comb begin
    if (!neg_q) begin
      res = (quo_q > MAG_POS_MAX) ? RES_MAX : LINE_W'(quo_q);
    end else begin
      res = (quo_q > MAG_NEG_MAX) ? RES_MIN : -LINE_W'(quo_q);
    end
  end

  // Output register holds one word until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_q;

  assign sts_o.clr_last   = clr_addr_q == LINE_AW'(LINE_DEPTH - 1);
  assign sts_o.tap_last   = tap_q == tap_last_idx;
  assign sts_o.pipe_busy  = v1_q | v2_q | v3_q;
  assign sts_o.div_done   = div_cnt_q == '0;
  assign sts_o.stage_last = stage_q == stg_last_idx;
  assign sts_o.out_full   = out_valid_q & ~out_ready_i;

endmodule

// ===== sv/cwfl_ctrl.sv =====
module cwfl_ctrl import cwfl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic req_type_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencing: clear, then per sample walk taps, drain, divide per stage.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == REQ_COEFF) begin
            cmd_o.coeff_wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd_o.issue = 1'b1;
        if (sts_i.tap_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          if (sts_i.stage_last) begin
            state_d = ST_FIN;
          end else begin
            cmd_o.next_stage = 1'b1;
            state_d          = ST_MAC;
          end
        end
      end
      ST_FIN: begin
        if (!sts_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/cascaded_windowed_fir_lowpass_top.sv =====
// Channel  | Direction | Handshake             | Payload
// input    | in        | in_valid_i/in_ready_o | req_type_i, sample_in_i, coeff_index_i,
//          |           |                       | coeff_value_i
// output   | out       | out_valid_o/out_ready_i | filtered_o
// config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A coefficient word goes into the window table and leaves the input open. For a
// sample word, one shared multiply-accumulate walks the T taps of each of the S
// stages through a three-stage pipeline, then a 37-step divider scales each
// stage sum. After reset a clearing pass zeroes the MAX_STAGES * MAX_TAPS delay
// line words; no input word is taken until it ends. A result waits in an output
// register, and the next word is taken meanwhile; a stalled output only holds
// the following sample at its last step. Configuration is taken every cycle.
module cascaded_windowed_fir_lowpass_top import cwfl_pkg::*; #(
  parameter int unsigned MAX_TAPS   = 64,
  parameter int unsigned MAX_STAGES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic signed [SAMPLE_W-1:0]  sample_in_i,
  input  logic [COEFF_IDX_W-1:0]      coeff_index_i,
  input  logic signed [WIN_W-1:0]     coeff_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [LINE_W-1:0]    filtered_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [GAIN_W-1:0]           cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Controller.
  cwfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  cwfl_dp #(
    .MAX_TAPS   (MAX_TAPS),
    .MAX_STAGES (MAX_STAGES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_in_i   (sample_in_i),
    .coeff_index_i (coeff_index_i),
    .coeff_value_i (coeff_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .filtered_o    (filtered_o)
  );

endmodule

// ===== sv/cwfl_checker.sv =====
module cwfl_checker import cwfl_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     req_type_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [LINE_W-1:0]        filtered_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o))
    else $error("result word changed while stalled");

  // A sample word closes the input once it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i == REQ_SAMPLE |=> !in_ready_o)
    else $error("input open right after a sample word");

  // A coefficient word never makes a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i == REQ_COEFF && !out_valid_o
    |=> !out_valid_o)
    else $error("result after a coefficient word");

  // A new result appears only at the end of sample work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without sample work");

endmodule

bind cascaded_windowed_fir_lowpass_top cwfl_checker u_cwfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .filtered_o  (filtered_o)
);
